// File: src/smtc_pkg.sv
// ----------------------------------------------------------------------------
// smtc_pkg: shared types and constants for the stick motion capture unit
// Holds the word layouts, function codes and capture constants.
// ----------------------------------------------------------------------------
package smtc_pkg;

  localparam int CaptureDepth = 1024;
  localparam int AddrW        = $clog2(CaptureDepth);
  localparam int CountW       = AddrW + 1;
  localparam int EntryW       = 52;

  localparam logic signed [7:0] PivotLevel = 8'sd64;
  localparam logic [31:0]       PivotLeadUs = 32'd50000;

  // Function codes of an input word.
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_REARM  = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  // Capture modes.
  localparam logic [1:0] MODE_SNAP  = 2'd0;
  localparam logic [1:0] MODE_PIVOT = 2'd1;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_SUB    = 3'd1;
  localparam logic [2:0] REG_THR    = 3'd2;
  localparam logic [2:0] REG_DWELL  = 3'd3;
  localparam logic [2:0] REG_STILL  = 3'd4;

  // Phase codes.
  localparam logic [1:0] PHASE_ARMED  = 2'd0;
  localparam logic [1:0] PHASE_REC    = 2'd1;
  localparam logic [1:0] PHASE_LOCKED = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic signed [7:0] main_x;
    logic signed [7:0] main_y;
    logic signed [7:0] sub_x;
    logic signed [7:0] sub_y;
    logic [19:0]       elapsed_us;
    logic [9:0]        read_index;
  } smtc_in_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic [10:0]       sample_count;
    logic              capture_done;
    logic              discarded;
    logic [9:0]        trim_start;
    logic signed [7:0] rd_main_x;
    logic signed [7:0] rd_main_y;
    logic signed [7:0] rd_sub_x;
    logic signed [7:0] rd_sub_y;
    logic [19:0]       rd_elapsed_us;
  } smtc_out_t;

  typedef struct packed {
    logic signed [7:0] mx;
    logic signed [7:0] my;
    logic signed [7:0] sx;
    logic signed [7:0] sy;
    logic [19:0]       el;
  } smtc_entry_t;

  // Saturating 32-bit add.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [19:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {13'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// File: src/smtc_ram.sv
// ----------------------------------------------------------------------------
// smtc_ram: generic single-port RAM
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module smtc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: src/stick_motion_triggered_capture_unit.sv
// ----------------------------------------------------------------------------
// stick_motion_triggered_capture_unit: triggered capture of stick samples
// Records stick samples after a motion trigger, trims pivot captures and
// reads stored entries back.
// ----------------------------------------------------------------------------
// Usage: raise start with a word on in_data while busy is low. The word is a
// sample, a rearm or a read. Exactly one result word per input word appears
// on out_data for one cycle, marked by out_valid; the receiver cannot stall.
// A rearm or a sample passes through S_EVAL (evaluate and write the sample
// buffer) and S_DONE (form the result), a read through S_EVAL, S_READ and
// S_RWAIT (buffer read latency). A sample that completes a pivot capture also
// walks the buffer backward, one entry per S_SCAN and S_SWAIT pair through
// the single RAM port, before S_DONE. busy is high from the cycle after
// acceptance until the result cycle, so the next word can be accepted in the
// result cycle. Configuration words are written on the cfg_ channel, which
// is always ready. Reset clears all control state and the registers to their
// defaults; the buffer contents are undefined until written, and no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module stick_motion_triggered_capture_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  smtc_pkg::smtc_in_t  in_data,
  output logic                out_valid,
  output smtc_pkg::smtc_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import smtc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_READ, S_RWAIT, S_SCAN, S_SWAIT, S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [1:0]  mode_r;
  logic        sub_r;
  logic [6:0]  thr_r;
  logic [21:0] dwell_r, still_r;

  // Capture state.
  smtc_in_t    in_r;
  logic [CountW-1:0] count_r;
  logic        rec_r, lock_r;
  logic signed [7:0] rest_x_r, rest_y_r, last_x_r, last_y_r;
  logic [31:0] still_t_r, origin_t_r;
  logic [AddrW-1:0]  trim_r;
  smtc_out_t   out_r;
  logic        out_v_r;

  // Scan state.
  logic [CountW-1:0] scan_i_r;
  logic        crossed_r, flipped_r, sign_pos_r;
  logic [31:0] acc_r;

  // RAM port.
  logic              ram_we;
  logic [AddrW-1:0]  ram_addr;
  smtc_entry_t       ram_wdata, ram_rdata;

  smtc_ram #(.Width(EntryW), .Depth(CaptureDepth)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Selected stick and window tests for the held sample.
  logic        pivot_m, snap_m, sub_sel;
  logic signed [7:0] px, py;
  logic signed [9:0] thr_s, rx, ry, dx, dy;
  logic        trig, still_ok, at_org;
  logic [CountW-1:0] cnt_inc;
  logic        full;
  logic [31:0] still_nxt, origin_nxt;
  logic        snap_stop, dwell_stop, scan_go;

  always_comb begin
    snap_m  = (mode_r == MODE_SNAP);
    pivot_m = (mode_r == MODE_PIVOT);
    sub_sel = sub_r && !pivot_m;
    px      = sub_sel ? in_r.sub_x : in_r.main_x;
    py      = sub_sel ? in_r.sub_y : in_r.main_y;
    thr_s   = {3'd0, thr_r};
    rx      = snap_m ? 10'(rest_x_r) : 10'sd0;
    ry      = snap_m ? 10'(rest_y_r) : 10'sd0;
    trig    = (10'(px) > rx + thr_s) || (10'(px) < rx - thr_s) ||
              (10'(py) > ry + thr_s) || (10'(py) < ry - thr_s);
    dx      = 10'(px) - 10'(last_x_r);
    dy      = 10'(py) - 10'(last_y_r);
    still_ok = (dx < thr_s) && (-dx < thr_s) && (dy < thr_s) && (-dy < thr_s);
    at_org  = (10'(px) < thr_s) && (10'(px) > -thr_s) &&
              (10'(py) < thr_s) && (10'(py) > -thr_s);
    cnt_inc = count_r + CountW'(1);
    full    = (cnt_inc >= CountW'(CaptureDepth));
    still_nxt  = still_ok ? sat_add(still_t_r, in_r.elapsed_us) : 32'd0;
    origin_nxt = at_org ? sat_add(origin_t_r, in_r.elapsed_us) : 32'd0;
    snap_stop  = full || (still_nxt >= {10'd0, still_r});
    dwell_stop = full || (origin_nxt >= {10'd0, dwell_r});
    scan_go    = (in_r.func == FUNC_SAMPLE) && !lock_r && rec_r && !snap_m &&
                 pivot_m && dwell_stop;
  end

  // Read address relative to the trim start.
  logic [AddrW-1:0] rd_addr;
  assign rd_addr = trim_r + AddrW'(in_r.read_index);

  // Scan step helpers.
  logic [31:0] acc_nxt;
  logic        e_big, e_opp, scan_hit;
  always_comb begin
    acc_nxt  = sat_add(acc_r, ram_rdata.el);
    e_big    = (ram_rdata.mx >= PivotLevel) || (ram_rdata.mx <= -PivotLevel);
    e_opp    = sign_pos_r ? (ram_rdata.mx < 8'sd0) : (ram_rdata.mx > 8'sd0);
    scan_hit = crossed_r && flipped_r && (acc_nxt >= PivotLeadUs);
  end

  // RAM port control: write the sample in S_EVAL, address reads elsewhere.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = rd_addr;
    ram_wdata = '{in_r.main_x, in_r.main_y, in_r.sub_x, in_r.sub_y, in_r.elapsed_us};
    if (state_r == S_EVAL && in_r.func == FUNC_SAMPLE && !lock_r) begin
      if (!rec_r) begin
        ram_we   = trig;
        ram_addr = '0;
      end else begin
        ram_we   = 1'b1;
        ram_addr = count_r[AddrW-1:0];
      end
    end else if (state_r == S_SCAN) begin
      ram_addr = scan_i_r[AddrW-1:0] - AddrW'(1);
    end
  end

  // Fields of a result: status, completion flags and an optional entry.
  function automatic smtc_out_t status(input logic l, input logic r,
                                       input logic [CountW-1:0] c,
                                       input logic [AddrW-1:0] t,
                                       input logic d, input logic x,
                                       input smtc_entry_t e, input logic hit);
    smtc_out_t o;
    o = '0;
    o.phase = l ? PHASE_LOCKED : (r ? PHASE_REC : PHASE_ARMED);
    o.sample_count = 11'(c);
    o.trim_start = 10'(t);
    o.capture_done = d;
    o.discarded = x;
    if (hit) begin
      o.rd_main_x     = e.mx;
      o.rd_main_y     = e.my;
      o.rd_sub_x      = e.sx;
      o.rd_sub_y      = e.sy;
      o.rd_elapsed_us = e.el;
    end
    return o;
  endfunction

  // Sequencer, configuration and capture state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      mode_r     <= 2'd0;
      sub_r      <= 1'b0;
      thr_r      <= 7'd5;
      dwell_r    <= 22'd50000;
      still_r    <= 22'd100000;
      count_r    <= '0;
      rec_r      <= 1'b0;
      lock_r     <= 1'b0;
      rest_x_r   <= '0;
      rest_y_r   <= '0;
      last_x_r   <= '0;
      last_y_r   <= '0;
      still_t_r  <= '0;
      origin_t_r <= '0;
      trim_r     <= '0;
      out_v_r    <= 1'b0;
      out_r      <= '0;
      scan_i_r   <= '0;
      crossed_r  <= 1'b0;
      flipped_r  <= 1'b0;
      sign_pos_r <= 1'b0;
      acc_r      <= '0;
      in_r       <= '0;
    end else begin
      out_v_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MODE:  mode_r  <= cfg_data[1:0];
          REG_SUB:   sub_r   <= cfg_data[0];
          REG_THR:   thr_r   <= cfg_data[6:0];
          REG_DWELL: dwell_r <= cfg_data[21:0];
          REG_STILL: still_r <= cfg_data[21:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            in_r    <= in_data;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (in_r.func == FUNC_READ) begin
            state_r <= S_READ;
          end else if (scan_go) begin
            state_r <= S_SCAN;
          end else begin
            state_r <= S_DONE;
          end
          case (in_r.func)
            FUNC_SAMPLE: begin
              if (!lock_r) begin
                if (!rec_r) begin
                  if (trig) begin
                    count_r <= CountW'(1);
                    trim_r  <= '0;
                    rec_r   <= 1'b1;
                  end
                end else if (snap_m) begin
                  still_t_r <= still_nxt;
                  last_x_r  <= px;
                  last_y_r  <= py;
                  count_r   <= (snap_stop && !at_org) ? '0 : cnt_inc;
                  if (snap_stop) begin
                    rec_r <= 1'b0;
                    if (at_org) begin
                      lock_r   <= 1'b1;
                      rest_x_r <= '0;
                      rest_y_r <= '0;
                      out_r.capture_done <= 1'b1;
                    end else begin
                      rest_x_r <= px;
                      rest_y_r <= py;
                      out_r.discarded <= 1'b1;
                    end
                  end
                end else begin
                  origin_t_r <= origin_nxt;
                  count_r    <= cnt_inc;
                  if (dwell_stop) begin
                    rec_r  <= 1'b0;
                    lock_r <= 1'b1;
                    out_r.capture_done <= 1'b1;
                    if (pivot_m) begin
                      scan_i_r  <= cnt_inc;
                      crossed_r <= 1'b0;
                      flipped_r <= 1'b0;
                      acc_r     <= '0;
                    end
                  end
                end
              end
            end
            FUNC_REARM: lock_r <= 1'b0;
            default: ;
          endcase
        end
        S_READ:  state_r <= S_RWAIT;
        S_RWAIT: begin
          out_r   <= status(lock_r, rec_r, count_r, trim_r, 1'b0, 1'b0, ram_rdata,
                            11'(in_r.read_index) < 11'(count_r));
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          // Address of entry scan_i - 1 is on the RAM port now.
          if (scan_i_r == '0) begin
            trim_r  <= '0;
            count_r <= (count_r == '0) ? '0 : count_r - CountW'(1);
            state_r <= S_DONE;
          end else begin
            state_r <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          scan_i_r <= scan_i_r - CountW'(1);
          state_r  <= scan_hit ? S_DONE : S_SCAN;
          if (!crossed_r) begin
            if (e_big) begin
              crossed_r  <= 1'b1;
              sign_pos_r <= ~ram_rdata.mx[7];
            end
          end else if (!flipped_r) begin
            if (e_opp) flipped_r <= 1'b1;
          end else begin
            acc_r <= acc_nxt;
            if (scan_hit) begin
              trim_r  <= AddrW'(scan_i_r - CountW'(1));
              count_r <= (scan_i_r > count_r) ? '0 : count_r - scan_i_r;
            end
          end
        end
        S_DONE: begin
          out_r   <= status(lock_r, rec_r, count_r, trim_r, out_r.capture_done,
                            out_r.discarded, ram_rdata, 1'b0);
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      // Flags of a previous result must not leak into the next one.
      if (state_r == S_IDLE && start) begin
        out_r.capture_done <= 1'b0;
        out_r.discarded    <= 1'b0;
      end
    end
  end

  // Results only while not busy, accepted words start work, no recording while locked, count within depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result outside the end of an item");
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");
  assert property (@(posedge clk) disable iff (!rst_n)
    !(rec_r && lock_r))
    else $error("recording while locked");
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CountW'(CaptureDepth))
    else $error("entry count beyond buffer depth");

endmodule

// File: bench/stick_motion_triggered_capture_unit_tb.sv
// ----------------------------------------------------------------------------
// stick_motion_triggered_capture_unit_tb: self-checking bench for the capture unit
// Drives sample, rearm and read words in random bursts. Seven settings are
// visited, covering modes 0 to 2 and thresholds 0 and 127. Each result word
// is checked against a behavioural predictor of the capture logic.
// ----------------------------------------------------------------------------
module stick_motion_triggered_capture_unit_tb;
  import smtc_pkg::*;

  // Predicts the capture unit and checks its result words in order.
  class capture_scoreboard;
    smtc_entry_t      store [CaptureDepth];
    int               count, trim, rest_x, rest_y, last_x, last_y;
    bit               rec, lck;
    logic [31:0]      still_t, origin_t;
    logic [1:0]       mode;
    bit               sub;
    int               thr;
    logic [31:0]      dwell_lim, still_lim;
    smtc_out_t        expected_q [$];
    int               mismatches, checked, captures, discards;

    function new();
      count = 0; trim = 0; rec = 0; lck = 0;
      rest_x = 0; rest_y = 0; last_x = 0; last_y = 0;
      still_t = 0; origin_t = 0;
      mode = MODE_SNAP; sub = 0; thr = 5; dwell_lim = 50000; still_lim = 100000;
      mismatches = 0; checked = 0; captures = 0; discards = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_MODE:  mode = val[1:0];
        REG_SUB:   sub = val[0];
        REG_THR:   thr = int'(val[6:0]);
        REG_DWELL: dwell_lim = {10'd0, val[21:0]};
        REG_STILL: still_lim = {10'd0, val[21:0]};
        default: ;
      endcase
    endfunction

    function logic [31:0] add_sat(logic [31:0] a, logic [19:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {13'd0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function bit near_origin(int x, int y);
      return x < thr && x > -thr && y < thr && y > -thr;
    endfunction

    // Backward scan for the start of the pivot motion.
    function int pivot_lead_start();
      bit          crossed, flipped;
      int          sgn, mx, i;
      logic [31:0] acc;
      crossed = 0; flipped = 0; sgn = 0; acc = 0;
      for (i = count - 1; i >= 0; i--) begin
        mx = int'($signed(store[i].mx));
        if (!crossed) begin
          if (mx >= 64 || mx <= -64) begin
            crossed = 1;
            sgn = mx;
          end
        end else if (!flipped) begin
          if ((sgn > 0 && mx < 0) || (sgn < 0 && mx > 0)) flipped = 1;
        end else begin
          acc = add_sat(acc, store[i].el);
          if (acc >= PivotLeadUs) return i;
        end
      end
      return 0;
    endfunction

    // Applies one sample word to the capture state.
    function void take_sample(smtc_in_t w, ref smtc_out_t r);
      smtc_entry_t e;
      bit          snap, pivot;
      int          px, py, rx, ry, s;
      snap = (mode == MODE_SNAP);
      pivot = (mode == MODE_PIVOT);
      e.mx = w.main_x; e.my = w.main_y; e.sx = w.sub_x; e.sy = w.sub_y;
      e.el = w.elapsed_us;
      px = (sub && !pivot) ? int'($signed(w.sub_x)) : int'($signed(w.main_x));
      py = (sub && !pivot) ? int'($signed(w.sub_y)) : int'($signed(w.main_y));
      if (!rec) begin
        rx = snap ? rest_x : 0;
        ry = snap ? rest_y : 0;
        if (px > rx + thr || px < rx - thr || py > ry + thr || py < ry - thr) begin
          store[0] = e;
          count = 1;
          trim = 0;
          rec = 1;
        end
        return;
      end
      store[count % CaptureDepth] = e;
      count++;
      if (snap) begin
        if ((px > last_x ? px - last_x : last_x - px) < thr &&
            (py > last_y ? py - last_y : last_y - py) < thr)
          still_t = add_sat(still_t, e.el);
        else
          still_t = 0;
        last_x = px; last_y = py;
        if (count >= CaptureDepth || still_t >= still_lim) begin
          rec = 0;
          if (near_origin(px, py)) begin
            lck = 1; r.capture_done = 1;
            rest_x = 0; rest_y = 0;
          end else begin
            count = 0; r.discarded = 1;
            rest_x = px; rest_y = py;
          end
        end
        return;
      end
      if (near_origin(px, py)) origin_t = add_sat(origin_t, e.el);
      else origin_t = 0;
      if (count >= CaptureDepth || origin_t >= dwell_lim) begin
        if (pivot) begin
          s = pivot_lead_start();
          trim = s;
          count = (s + 1 > count) ? 0 : count - s - 1;
        end
        rec = 0; lck = 1; r.capture_done = 1;
      end
    endfunction

    // Notes an accepted input word and queues the result it must produce.
    function void note_input(smtc_in_t w);
      smtc_out_t   r;
      smtc_entry_t e;
      r = '0;
      case (w.func)
        FUNC_SAMPLE: if (!lck) take_sample(w, r);
        FUNC_REARM:  lck = 0;
        FUNC_READ: begin
          if (int'(w.read_index) < count) begin
            e = store[(trim + int'(w.read_index)) % CaptureDepth];
            r.rd_main_x = e.mx; r.rd_main_y = e.my;
            r.rd_sub_x = e.sx; r.rd_sub_y = e.sy;
            r.rd_elapsed_us = e.el;
          end
        end
        default: ;
      endcase
      r.phase = lck ? PHASE_LOCKED : (rec ? PHASE_REC : PHASE_ARMED);
      r.sample_count = count[10:0];
      r.trim_start = trim[9:0];
      expected_q.push_back(r);
    endfunction

    function string show(smtc_out_t r);
      return $sformatf("ph=%0d cnt=%0d done=%0d disc=%0d trim=%0d rd=%0d,%0d,%0d,%0d,%0d",
                       r.phase, r.sample_count, r.capture_done, r.discarded,
                       r.trim_start, r.rd_main_x, r.rd_main_y, r.rd_sub_x,
                       r.rd_sub_y, r.rd_elapsed_us);
    endfunction

    // Checks one result word against the oldest expectation.
    function void check_result(smtc_out_t act);
      smtc_out_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %s", show(act));
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (exp.capture_done) captures++;
      if (exp.discarded) discards++;
      if (act.phase !== exp.phase || act.sample_count !== exp.sample_count ||
          act.capture_done !== exp.capture_done || act.discarded !== exp.discarded ||
          act.trim_start !== exp.trim_start || act.rd_main_x !== exp.rd_main_x ||
          act.rd_main_y !== exp.rd_main_y || act.rd_sub_x !== exp.rd_sub_x ||
          act.rd_sub_y !== exp.rd_sub_y || act.rd_elapsed_us !== exp.rd_elapsed_us) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at word %0d", checked);
          $display("  expected %s", show(exp));
          $display("  actual   %s", show(act));
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  smtc_in_t  in_data;
  logic      out_valid;
  smtc_out_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  capture_scoreboard sb = new();
  int words_sent = 0;
  int burst_left = 4;

  stick_motion_triggered_capture_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Input and result monitors.
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_input(in_data);
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // Watchdog.
  initial begin
    #20000000;
    $display("timeout waiting for result words");
    $display("CHECK FAILED");
    $finish;
  end

  function automatic smtc_in_t make_word(logic [1:0] f, int mx, int my, int sx, int sy,
                                         int el, int ri);
    smtc_in_t w;
    w.func = f;
    w.main_x = mx[7:0]; w.main_y = my[7:0];
    w.sub_x = sx[7:0]; w.sub_y = sy[7:0];
    w.elapsed_us = el[19:0];
    w.read_index = ri[9:0];
    return w;
  endfunction

  function automatic int any8();
    return int'($urandom_range(0, 255)) - 128;
  endfunction

  // Sends one word, waiting for acceptance, then idles between bursts.
  task automatic send_word(smtc_in_t w);
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Waits until every expected result word has arrived.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Holds one register write on the channel until it is taken.
  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic send_noise();
    send_word(make_word(2'($urandom_range(0, 2)), any8(), any8(), any8(), any8(),
                        $urandom_range(0, 1000000), $urandom_range(0, 1023)));
  endtask

  // One well-formed capture: trigger, motion, settle, read back, rearm.
  task automatic run_capture();
    int n, k, mag, v, pos, bound;
    bit pivot;
    pivot = (sb.mode == MODE_PIVOT);
    mag = (sb.thr >= 127) ? 128 : $urandom_range(sb.thr + 1, 127);
    v = ($urandom_range(0, 1) || mag == 128) ? -mag : mag;
    send_word(make_word(FUNC_SAMPLE, v, any8(), v, any8(), $urandom_range(0, 20000), 0));
    n = $urandom_range(2, 12);
    for (k = 0; k < n; k++) begin
      if (pivot)
        send_word(make_word(FUNC_SAMPLE, -int'($urandom_range(1, 128)), any8(), any8(),
                            any8(), $urandom_range(5000, 20000), 0));
      else
        send_word(make_word(FUNC_SAMPLE, any8(), any8(), any8(), any8(),
                            $urandom_range(0, 20000), 0));
    end
    // The pivot swing ends on the opposite side.
    if (pivot) begin
      for (k = 0; k < 2; k++)
        send_word(make_word(FUNC_SAMPLE, $urandom_range(64, 127), any8(), any8(), any8(),
                            $urandom_range(1000, 20000), 0));
    end
    pos = (sb.mode == MODE_SNAP && $urandom_range(0, 3) == 0) ? 90 : 0;
    bound = 40;
    for (k = 0; k < bound && sb.rec; k++)
      send_word(make_word(FUNC_SAMPLE, pos, pos, pos, pos, $urandom_range(0, 25000), 0));
    n = $urandom_range(2, 6);
    for (k = 0; k < n; k++)
      send_word(make_word(FUNC_READ, any8(), any8(), any8(), any8(),
                          $urandom_range(0, 1000000),
                          ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, sb.count + 1)));
    send_word(make_word(FUNC_REARM, any8(), any8(), any8(), any8(), 0, 0));
  endtask

  // Configuration settings per phase: mode, sub stick, threshold, dwell, still time.
  int set_mode  [7] = '{0, 1, 2, 0, 2, 1, 2};
  int set_sub   [7] = '{0, 0, 1, 1, 0, 1, 0};
  int set_thr   [7] = '{5, 20, 10, 127, 0, 64, 1};
  int set_dwell [7] = '{50000, 30000, 20000, 0, 4000000, 0, 1000};
  int set_still [7] = '{100000, 60000, 40000, 0, 4000000, 4000000, 3000};

  // Main stimulus.
  initial begin
    int p, target;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset settings.
    send_word(make_word(FUNC_READ, 0, 0, 0, 0, 0, 0));
    send_word(make_word(FUNC_REARM, 0, 0, 0, 0, 0, 0));
    send_word(make_word(FUNC_SAMPLE, 3, -3, 0, 0, 0, 0));
    send_word(make_word(FUNC_SAMPLE, 127, 127, -128, -128, 0, 0));
    send_word(make_word(FUNC_SAMPLE, -128, -128, 127, 127, 1000000, 0));
    send_word(make_word(FUNC_SAMPLE, 0, 0, 0, 0, 0, 0));
    send_word(make_word(FUNC_SAMPLE, 0, 0, 0, 0, 1000000, 1023));
    send_word(make_word(FUNC_SAMPLE, 0, 0, 0, 0, 1000000, 0));
    send_word(make_word(FUNC_SAMPLE, 100, 100, 100, 100, 500, 0));
    send_word(make_word(FUNC_READ, 0, 0, 0, 0, 0, 0));
    send_word(make_word(FUNC_READ, 0, 0, 0, 0, 0, 1));
    send_word(make_word(FUNC_READ, 0, 0, 0, 0, 0, 1023));
    send_word(make_word(FUNC_REARM, 0, 0, 0, 0, 0, 0));
    send_word(make_word(FUNC_SAMPLE, 60, 0, 0, 0, 0, 0));
    send_word(make_word(FUNC_SAMPLE, 60, 0, 0, 0, 1000000, 0));
    send_word(make_word(FUNC_SAMPLE, 60, 0, 0, 0, 1000000, 0));
    send_word(make_word(FUNC_READ, 0, 0, 0, 0, 0, 0));
    drain();

    // Random captures and noise under each setting.
    for (p = 0; p < 7; p++) begin
      drain();
      cfg_write(REG_MODE, set_mode[p]);
      cfg_write(REG_SUB, set_sub[p]);
      cfg_write(REG_THR, set_thr[p]);
      cfg_write(REG_DWELL, set_dwell[p]);
      cfg_write(REG_STILL, set_still[p]);
      cfg_valid <= 1'b0;
      target = words_sent + 140;
      while (words_sent < target) begin
        if ($urandom_range(0, 3) != 0) run_capture();
        else send_noise();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d words over 7 settings; %0d results checked.", words_sent, sb.checked);
    $display("Captures completed: %0d, discarded: %0d.", sb.captures, sb.discards);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
